/* sv/text_terminal_cell_engine_core_assert.svh */
// assertion macros used by the text terminal cell engine rtl
`ifndef TEXT_TERMINAL_CELL_ENGINE_CORE_ASSERT_SVH
`define TEXT_TERMINAL_CELL_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define TTE_ASSERT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tte assertion failed");

// next-cycle implication
`define TTE_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tte assertion failed");

`endif

/* sv/tte_pkg.sv */
// shared constants and types of the text terminal cell engine
package tte_pkg;

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int CELL_COUNT   = ROWS * COLUMNS;
	localparam int SCROLL_COUNT = CELL_COUNT - COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int SCAN_W = $clog2(COLUMNS + 1);

	localparam int FUNC_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int RADDR_W = 11;
	localparam int ROW_FW  = 5;
	localparam int COL_FW  = 7;
	localparam int LOC_FW  = 11;
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;

	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
	localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, SPACE_CODE};

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_BS    = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_READ  = 2'd3
	} tte_func_t;

	// finished command handed to the output register
	typedef struct packed {
		logic              valid;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CELL_W-1:0] data;
	} tte_fin_t;

endpackage

/* sv/tte_cmd_if.sv */
// command channel: valid/ready plus command payload
interface tte_cmd_if
	import tte_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [CHAR_W-1:0]  char_code;
	logic [RADDR_W-1:0] read_address;

	modport source (output valid, output func, output char_code, output read_address,
		input ready);
	modport sink (input valid, input func, input char_code, input read_address,
		output ready);
endinterface

/* sv/tte_res_if.sv */
// result channel: valid/ready plus cursor and cell payload
interface tte_res_if
	import tte_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [ROW_FW-1:0] cursor_row;
	logic [COL_FW-1:0] cursor_col;
	logic [LOC_FW-1:0] cursor_addr;
	logic [CELL_W-1:0] cell_data;

	modport source (output valid, output cursor_row, output cursor_col,
		output cursor_addr, output cell_data, input ready);
	modport sink (input valid, input cursor_row, input cursor_col,
		input cursor_addr, input cell_data, output ready);
endinterface

/* sv/tte_ram.sv */
// generic simple dual-port ram with registered read
module tte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* sv/tte_ctrl.sv */
// command sequencer: cursor, shared address adder and the cell store
`include "text_terminal_cell_engine_core_assert.svh"

module tte_ctrl
	import tte_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [FUNC_W-1:0]  func,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [RADDR_W-1:0] read_address,
	input  logic [ATTR_W-1:0]  blank_attr,
	input  logic               out_free,
	output tte_fin_t           fin
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_WR,
		S_SCAN,
		S_SCROLL,
		S_FILL,
		S_READ,
		S_DONE
	} state_t;

	state_t state_q, state_d;

	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic [SCAN_W-1:0] scan_q, scan_d;
	logic              init_q, init_d;
	logic              pend_s1, pend_d;
	logic [COL_W-1:0]  idx_s1, idx_d;
	logic              wpend_s1, wpend_d;
	logic [ADDR_W-1:0] wptr_s1, wptr_d;
	logic [FUNC_W-1:0] op_q, op_d;
	logic [CHAR_W-1:0] char_q, char_d;
	logic [CELL_W-1:0] data_q, data_d;

	logic              fin_now;
	logic [CELL_W-1:0] fin_data;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	// shared address unit
	logic [ADDR_W-1:0] row_base, add_a, add_b, add_sum;

	assign row_base = ADDR_W'(row_q * COLUMNS);

	always_comb begin
		add_a = row_base;
		add_b = ADDR_W'(col_q);
		if (state_q == S_SCROLL) begin
			add_a = ptr_q;
			add_b = ADDR_W'(COLUMNS);
		end else if (state_q == S_SCAN) begin
			add_b = ADDR_W'(scan_q - 1'b1);
		end
	end

	assign add_sum = add_a + add_b;

	tte_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		col_d     = col_q;
		ptr_d     = ptr_q;
		scan_d    = scan_q;
		init_d    = init_q;
		pend_d    = pend_s1;
		idx_d     = idx_s1;
		wpend_d   = wpend_s1;
		wptr_d    = wptr_s1;
		op_d      = op_q;
		char_d    = char_q;
		data_d    = data_q;
		fin_now   = 1'b0;
		fin_data  = data_q;
		cmd_ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = add_sum;
		ram_raddr = add_sum;
		ram_wdata = {ram_rdata[CELL_W-1:CHAR_W], SPACE_CODE};

		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				fin_data  = '0;
				if (cmd_valid) begin
					data_d = '0;
					op_d   = func;
					char_d = char_code;
					unique case (func)
						FUNC_PUT: begin
							if (char_code == NEWLINE_CODE) begin
								col_d = '0;
								if (row_q == ROW_W'(ROWS - 1)) begin
									ptr_d   = '0;
									wpend_d = 1'b0;
									state_d = S_SCROLL;
								end else begin
									row_d   = row_q + 1'b1;
									fin_now = 1'b1;
								end
							end else begin
								// fetch the cell under the cursor, attribute is kept
								ram_re  = 1'b1;
								state_d = S_WR;
							end
						end
						FUNC_BS: begin
							if (col_q != '0) begin
								col_d   = col_q - 1'b1;
								state_d = S_RD;
							end else if (row_q != '0) begin
								row_d   = row_q - 1'b1;
								scan_d  = SCAN_W'(COLUMNS);
								pend_d  = 1'b0;
								state_d = S_SCAN;
							end else begin
								fin_now = 1'b1;
							end
						end
						FUNC_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							ptr_d   = '0;
							state_d = S_FILL;
						end
						FUNC_READ: begin
							if (32'(read_address) < CELL_COUNT) begin
								ram_re    = 1'b1;
								ram_raddr = ADDR_W'(read_address);
								state_d   = S_READ;
							end else begin
								fin_now = 1'b1;
							end
						end
					endcase
				end
			end
			S_RD: begin
				ram_re  = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				ram_we = 1'b1;
				if (op_q == FUNC_PUT) begin
					ram_wdata = {ram_rdata[CELL_W-1:CHAR_W], char_q};
					if (col_q == COL_W'(COLUMNS - 1)) begin
						col_d = '0;
						if (row_q == ROW_W'(ROWS - 1)) begin
							ptr_d   = '0;
							wpend_d = 1'b0;
							state_d = S_SCROLL;
						end else begin
							row_d   = row_q + 1'b1;
							fin_now = 1'b1;
						end
					end else begin
						col_d   = col_q + 1'b1;
						fin_now = 1'b1;
					end
				end else begin
					fin_now = 1'b1;
				end
			end
			S_SCAN: begin
				// reads run one cell ahead of the space check
				if (pend_s1 && ram_rdata[CHAR_W-1:0] != SPACE_CODE) begin
					if (ram_rdata[CHAR_W-1:0] == NEWLINE_CODE)
						col_d = '0;
					else if (idx_s1 == COL_W'(COLUMNS - 1))
						col_d = idx_s1;
					else
						col_d = idx_s1 + 1'b1;
					state_d = S_RD;
				end else if (scan_q == '0) begin
					col_d   = '0;
					state_d = S_RD;
				end else begin
					ram_re = 1'b1;
					pend_d = 1'b1;
					idx_d  = COL_W'(scan_q - 1'b1);
					scan_d = scan_q - 1'b1;
				end
			end
			S_SCROLL: begin
				// copy cell ptr+columns down to ptr, each write in the cycle after its read
				if (wpend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = wptr_s1;
					ram_wdata = ram_rdata;
				end
				if (ptr_q == ADDR_W'(SCROLL_COUNT)) begin
					wpend_d = 1'b0;
					state_d = S_FILL;
				end else begin
					ram_re  = 1'b1;
					wpend_d = 1'b1;
					wptr_d  = ptr_q;
					ptr_d   = ptr_q + 1'b1;
				end
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = init_q ? RESET_CELL : {blank_attr, SPACE_CODE};
				if (ptr_q == ADDR_W'(CELL_COUNT - 1)) begin
					if (init_q) begin
						init_d  = 1'b0;
						state_d = S_IDLE;
					end else begin
						fin_now = 1'b1;
					end
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			S_READ: begin
				fin_data = ram_rdata;
				data_d   = ram_rdata;
				fin_now  = 1'b1;
			end
			S_DONE: begin
				fin_now = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// park in done while the output register is still full
		if (fin_now)
			state_d = out_free ? S_IDLE : S_DONE;
	end

	always_comb begin
		fin.valid = fin_now && out_free;
		fin.row   = row_d;
		fin.col   = col_d;
		fin.data  = fin_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_FILL;
			init_q   <= 1'b1;
			ptr_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			scan_q   <= '0;
			pend_s1  <= 1'b0;
			wpend_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			init_q   <= init_d;
			ptr_q    <= ptr_d;
			row_q    <= row_d;
			col_q    <= col_d;
			scan_q   <= scan_d;
			pend_s1  <= pend_d;
			wpend_s1 <= wpend_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx_d;
		wptr_s1 <= wptr_d;
		op_q    <= op_d;
		char_q  <= char_d;
		data_q  <= data_d;
	end

	`TTE_ASSERT(a_cursor_range, clk, arst_n, 1'b1, (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
	`TTE_ASSERT(a_fin_has_room, clk, arst_n, fin.valid, out_free)
	`TTE_ASSERT(a_no_accept_in_sweep, clk, arst_n, init_q, !cmd_ready)
	`TTE_ASSERT(a_ports_apart, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr)
	`TTE_ASSERT(a_write_after_read, clk, arst_n, state_q == S_WR, $past(ram_re))
endmodule

/* sv/text_terminal_cell_engine_core.sv */
// top level of the text terminal cell engine: config register and result register
//
//  channel | dir | handshake     | payload
//  cmd     | in  | valid/ready   | func, char_code, read_address
//  res     | out | valid/ready   | cursor_row, cursor_col, cursor_addr, cell_data
//  cfg     | in  | cfg_we        | cfg_wdata (blank attribute)
//
// put of a character: read then write of the cursor cell; newline only moves the cursor unless it scrolls
// read: fetch of the addressed cell; backspace: read then write, after a scan of the row above at column 0
// scroll: rows*columns - columns cells copied through the one ram port pair, then columns cells filled
// clear: rows*columns cells, one cell written per cycle
// after reset a sweep writes every cell blank before the first command beat
// one command at a time; the result register lets a new command start while a result waits

module text_terminal_cell_engine_core
	import tte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	tte_cmd_if.sink           cmd,
	tte_res_if.source         res,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata
);
	logic [ATTR_W-1:0] blank_attr_q;
	logic              res_valid_q;
	logic [ROW_FW-1:0] res_row_q;
	logic [COL_FW-1:0] res_col_q;
	logic [LOC_FW-1:0] res_loc_q;
	logic [CELL_W-1:0] res_data_q;

	logic              out_free;
	tte_fin_t          fin;
	logic [ADDR_W-1:0] fin_loc;

	assign out_free = !res_valid_q || res.ready;

	tte_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd.valid),
		.cmd_ready    (cmd.ready),
		.func         (cmd.func),
		.char_code    (cmd.char_code),
		.read_address (cmd.read_address),
		.blank_attr   (blank_attr_q),
		.out_free     (out_free),
		.fin          (fin)
	);

	assign fin_loc = ADDR_W'(fin.row * COLUMNS) + ADDR_W'(fin.col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_attr_q <= RESET_ATTR;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				blank_attr_q <= cfg_wdata;
			if (fin.valid)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			res_row_q  <= ROW_FW'(fin.row);
			res_col_q  <= COL_FW'(fin.col);
			res_loc_q  <= LOC_FW'(fin_loc);
			res_data_q <= fin.data;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.cursor_row  = res_row_q;
	assign res.cursor_col  = res_col_q;
	assign res.cursor_addr = res_loc_q;
	assign res.cell_data   = res_data_q;
endmodule

/* tb/sv/text_terminal_cell_engine_core_test.sv */
// testbench of the text terminal cell engine: shadow screen, directed and random commands, result checks
module text_terminal_cell_engine_core_test
	import tte_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		tte_func_t          func;
		logic [CHAR_W-1:0]  char_code;
		logic [RADDR_W-1:0] read_address;
	} command_t;

	typedef struct packed {
		logic [ROW_FW-1:0] row;
		logic [COL_FW-1:0] col;
		logic [LOC_FW-1:0] location;
		logic [CELL_W-1:0] data;
	} cursor_report_t;

	// shadow copy of the screen and cursor, and the cursor reports still owed by the block
	class screen_shadow;
		logic [CELL_W-1:0] cells [CELL_COUNT];
		logic [ATTR_W-1:0] blank_attr;
		int cur_row;
		int cur_col;
		int errors;
		cursor_report_t pending_reports[$];

		function new();
			for (int i = 0; i < CELL_COUNT; i++)
				cells[i] = RESET_CELL;
			blank_attr = RESET_ATTR;
			cur_row = 0;
			cur_col = 0;
			errors = 0;
		endfunction

		function void take_command(command_t c);
			cursor_report_t rep;
			int k;
			int n;
			logic [CELL_W-1:0] blank;
			blank = {blank_attr, SPACE_CODE};
			rep.data = '0;
			case (c.func)
				FUNC_PUT: begin
					if (c.char_code == NEWLINE_CODE) begin
						cur_row++;
						cur_col = 0;
					end else begin
						k = cur_row * COLUMNS + cur_col;
						cells[k][CHAR_W-1:0] = c.char_code;
						cur_col++;
					end
					if (cur_col >= COLUMNS) begin
						cur_row++;
						cur_col = 0;
					end
					// past the bottom row: everything moves up and the last row goes blank
					if (cur_row >= ROWS) begin
						for (k = 0; k < SCROLL_COUNT; k++)
							cells[k] = cells[k + COLUMNS];
						for (k = SCROLL_COUNT; k < CELL_COUNT; k++)
							cells[k] = blank;
						cur_row = ROWS - 1;
					end
				end
				FUNC_BS: begin
					if (cur_row != 0 || cur_col != 0) begin
						if (cur_col == 0) begin
							// back onto the row above, just past its last non-space character (column 0 after a newline)
							cur_row--;
							n = COLUMNS;
							while (n > 0 &&
								cells[cur_row * COLUMNS + n - 1][CHAR_W-1:0] == SPACE_CODE)
								n--;
							if (n == 0)
								cur_col = 0;
							else if (cells[cur_row * COLUMNS + n - 1][CHAR_W-1:0] == NEWLINE_CODE)
								cur_col = 0;
							else
								cur_col = (n >= COLUMNS) ? COLUMNS - 1 : n;
						end else begin
							cur_col--;
						end
						k = cur_row * COLUMNS + cur_col;
						cells[k][CHAR_W-1:0] = SPACE_CODE;
					end
				end
				FUNC_CLEAR: begin
					for (k = 0; k < CELL_COUNT; k++)
						cells[k] = blank;
					cur_row = 0;
					cur_col = 0;
				end
				FUNC_READ: begin
					if (c.read_address < CELL_COUNT)
						rep.data = cells[c.read_address];
				end
			endcase
			rep.row = ROW_FW'(cur_row);
			rep.col = COL_FW'(cur_col);
			rep.location = LOC_FW'(cur_row * COLUMNS + cur_col);
			pending_reports.push_back(rep);
		endfunction

		function void compare_field(string label, logic [CELL_W-1:0] want,
			logic [CELL_W-1:0] got);
			if (got !== want) begin
				$display("%0t ns: %s expected %0d got %0d", $time, label, want, got);
				errors++;
			end
		endfunction

		function void match_report(cursor_report_t got);
			cursor_report_t want;
			if (pending_reports.size() == 0) begin
				$display("%0t ns: unexpected result beat, expected none got row %0d col %0d",
					$time, got.row, got.col);
				errors++;
				return;
			end
			want = pending_reports.pop_front();
			compare_field("cursor_row", want.row, got.row);
			compare_field("cursor_col", want.col, got.col);
			compare_field("cursor_addr", want.location, got.location);
			compare_field("cell_data", want.data, got.data);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [ATTR_W-1:0] cfg_wdata;

	tte_cmd_if cmd_ch ();
	tte_res_if res_ch ();

	screen_shadow shadow = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int recv_hold = 0;
	int items_sent = 0;

	text_terminal_cell_engine_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: ready decided at the falling edge, beat taken at the rising edge
	initial begin
		cursor_report_t got;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				recv_hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.row = res_ch.cursor_row;
				got.col = res_ch.cursor_col;
				got.location = res_ch.cursor_addr;
				got.data = res_ch.cell_data;
				shadow.match_report(got);
			end
		end
	end

	task automatic issue(tte_func_t f, logic [CHAR_W-1:0] ch, logic [RADDR_W-1:0] addr);
		command_t c;
		c.func = f;
		c.char_code = ch;
		c.read_address = addr;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= f;
		cmd_ch.char_code <= ch;
		cmd_ch.read_address <= addr;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		shadow.take_command(c);
		items_sent++;
	endtask

	task automatic wait_drained();
		while (shadow.pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_blank_attribute(logic [ATTR_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow.blank_attr = value;
	endtask

	function automatic logic [CHAR_W-1:0] pick_glyph();
		int sel;
		sel = $urandom_range(99);
		if (sel < 75)
			return CHAR_W'($urandom_range(8'h7E, 8'h21));
		if (sel < 85)
			return SPACE_CODE;
		return CHAR_W'($urandom_range(255));
	endfunction

	// mostly around the cursor, where the writes land
	function automatic logic [RADDR_W-1:0] pick_read_address();
		int sel;
		int row;
		sel = $urandom_range(99);
		row = shadow.cur_row;
		if (sel < 40)
			return RADDR_W'(row * COLUMNS + $urandom_range(COLUMNS - 1));
		if (sel < 55)
			return RADDR_W'(((row == 0) ? 0 : row - 1) * COLUMNS + $urandom_range(COLUMNS - 1));
		if (sel < 90)
			return RADDR_W'($urandom_range(CELL_COUNT - 1));
		return RADDR_W'($urandom_range((1 << RADDR_W) - 1, CELL_COUNT));
	endfunction

	task automatic run_directed();
		issue(FUNC_READ, 8'h00, 11'd0);
		issue(FUNC_READ, 8'hFF, 11'd2047);
		issue(FUNC_READ, 8'h00, 11'd2000);
		issue(FUNC_BS, 8'h00, 11'd0);
		issue(FUNC_PUT, 8'hFF, 11'd0);
		issue(FUNC_PUT, 8'h00, 11'd2047);
		issue(FUNC_PUT, SPACE_CODE, 11'd0);
		issue(FUNC_PUT, 8'h41, 11'd0);
		issue(FUNC_BS, 8'hFF, 11'd2047);
		issue(FUNC_READ, 8'h00, 11'd2);
		issue(FUNC_PUT, NEWLINE_CODE, 11'd0);
		issue(FUNC_BS, 8'h00, 11'd0);
		issue(FUNC_READ, 8'h00, 11'd1);
		issue(FUNC_PUT, NEWLINE_CODE, 11'd0);
		issue(FUNC_PUT, NEWLINE_CODE, 11'd0);
		issue(FUNC_BS, 8'h00, 11'd0);
		issue(FUNC_PUT, 8'h55, 11'd0);
		issue(FUNC_PUT, 8'hAA, 11'd0);
		issue(FUNC_READ, 8'h00, 11'd1999);
		issue(FUNC_READ, 8'h00, 11'd81);
		issue(FUNC_CLEAR, 8'hFF, 11'd2047);
		issue(FUNC_READ, 8'h00, 11'd0);
		issue(FUNC_READ, 8'h00, 11'd1024);
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
	endtask

	task automatic run_random_phase(int count, int hold);
		int start;
		int sel;
		int len;
		start = items_sent;
		// each phase opens on a clear so the new blank attribute shows up everywhere
		issue(FUNC_CLEAR, CHAR_W'($urandom), RADDR_W'($urandom));
		while (items_sent - start < count) begin
			if (hold > 0 && items_sent - start >= count / 2) begin
				recv_hold = hold;
				hold = 0;
			end
			sel = $urandom_range(99);
			if (sel < 38) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(12, 1);
				repeat (len)
					issue(FUNC_PUT, pick_glyph(), RADDR_W'($urandom));
			end else if (sel < 50) begin
				repeat ($urandom_range(3, 1))
					issue(FUNC_PUT, NEWLINE_CODE, RADDR_W'($urandom));
			end else if (sel < 65) begin
				repeat ($urandom_range(6, 1))
					issue(FUNC_BS, CHAR_W'($urandom), RADDR_W'($urandom));
			end else if (sel < 90) begin
				repeat ($urandom_range(3, 1))
					issue(FUNC_READ, CHAR_W'($urandom), pick_read_address());
			end else if (sel < 92) begin
				issue(FUNC_CLEAR, CHAR_W'($urandom), RADDR_W'($urandom));
			end else if (sel < 94) begin
				// a full row of text, then backspace from the start of the next row
				if (shadow.cur_col != 0)
					issue(FUNC_PUT, NEWLINE_CODE, RADDR_W'($urandom));
				repeat (COLUMNS)
					issue(FUNC_PUT, CHAR_W'($urandom_range(8'hFF, 8'h21)), RADDR_W'($urandom));
				issue(FUNC_BS, CHAR_W'($urandom), RADDR_W'($urandom));
				issue(FUNC_READ, CHAR_W'($urandom), pick_read_address());
			end else begin
				issue(FUNC_PUT, NEWLINE_CODE, RADDR_W'($urandom));
				issue(FUNC_BS, CHAR_W'($urandom), RADDR_W'($urandom));
			end
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_PUT;
		cmd_ch.char_code = '0;
		cmd_ch.read_address = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		write_blank_attribute(8'h00);
		run_random_phase(450, 400);

		write_blank_attribute(8'hFF);
		send_idle_pct = 49;
		recv_stall_pct = 0;
		run_random_phase(450, 0);

		write_blank_attribute(ATTR_W'($urandom));
		send_idle_pct = 0;
		recv_stall_pct = 49;
		run_random_phase(450, 0);

		write_blank_attribute(ATTR_W'($urandom));
		send_idle_pct = 24;
		recv_stall_pct = 24;
		run_random_phase(450, 0);

		wait_drained();
		repeat (100) @(posedge clk);
		if (shadow.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timeout with %0d results outstanding", shadow.pending_reports.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* text_terminal_cell_engine_core.f */
+incdir+sv
sv/tte_pkg.sv
sv/tte_cmd_if.sv
sv/tte_res_if.sv
sv/tte_ram.sv
sv/tte_ctrl.sv
sv/text_terminal_cell_engine_core.sv
tb/sv/text_terminal_cell_engine_core_test.sv
